[rtl/vector_to_heading_atan2_defines.svh]
// ----------------------------------------------------------------------------
// vector_to_heading_atan2_defines.svh
// Assertion macros shared by the vector-to-heading block.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TO_HEADING_ATAN2_DEFINES_SVH
`define VECTOR_TO_HEADING_ATAN2_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define VTH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define VTH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vth_pkg.sv]
// ----------------------------------------------------------------------------
// vth_pkg
// Types, constants and the arctangent table of the vector-to-heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vth_pkg;

  localparam int MAG_W  = 32;   // input component width
  localparam int SM_W   = 15;   // magnitude width after scaling
  localparam int LOW_W  = 16;   // dividend low bits shifted in by the divider
  localparam int CNT_W  = 5;    // divider step counter
  localparam int IDX_W  = 7;    // table index, 0..64
  localparam int ANG_W  = 22;   // octant angle, 0..32 units in 16.16
  localparam int DIFF_W = 16;   // table step between neighbors
  localparam int PROD_W = 31;   // step times remainder
  localparam int HW_W   = 25;   // heading arithmetic before the final wrap
  localparam int HEAD_W = 24;

  localparam logic [CNT_W-1:0] Q1_STEPS = 5'd7;
  localparam logic [CNT_W-1:0] Q2_STEPS = 5'd16;
  localparam logic [IDX_W-1:0] IDX_LAST = 7'd64;

  localparam logic [HW_W-1:0] ANG_QUARTER = 25'd4194304;   // 64 << 16
  localparam logic [HW_W-1:0] ANG_HALF    = 25'd8388608;   // 128 << 16
  localparam logic [HW_W-1:0] ANG_TURN    = 25'd16777216;  // 256 << 16

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DIV1,
    S_LOOKUP,
    S_PROD,
    S_DIV2,
    S_FIN
  } state_t;

  // Command to the shared divider
  typedef struct packed {
    logic             start;
    logic [SM_W-1:0]  rem_init;
    logic [LOW_W-1:0] low;
    logic [CNT_W-1:0] steps;
  } div_cmd_t;

  // Status and result of the shared divider
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LOW_W-1:0] quo;
    logic [SM_W-1:0]  rem;
  } div_res_t;

  // Arctangent of idx/64 in 16.16 heading units, one octant
  function automatic logic [ANG_W-1:0] atan_rom(input logic [IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      7'd0:  v = 22'd0;       7'd1:  v = 22'd41718;   7'd2:  v = 22'd83416;
      7'd3:  v = 22'd125073;  7'd4:  v = 22'd166669;  7'd5:  v = 22'd208185;
      7'd6:  v = 22'd249600;  7'd7:  v = 22'd290894;  7'd8:  v = 22'd332050;
      7'd9:  v = 22'd373047;  7'd10: v = 22'd413869;  7'd11: v = 22'd454496;
      7'd12: v = 22'd494912;  7'd13: v = 22'd535100;  7'd14: v = 22'd575043;
      7'd15: v = 22'd614727;  7'd16: v = 22'd654136;  7'd17: v = 22'd693257;
      7'd18: v = 22'd732076;  7'd19: v = 22'd770579;  7'd20: v = 22'd808756;
      7'd21: v = 22'd846595;  7'd22: v = 22'd884085;  7'd23: v = 22'd921217;
      7'd24: v = 22'd957981;  7'd25: v = 22'd994370;  7'd26: v = 22'd1030375;
      7'd27: v = 22'd1065990; 7'd28: v = 22'd1101209; 7'd29: v = 22'd1136026;
      7'd30: v = 22'd1170436; 7'd31: v = 22'd1204436; 7'd32: v = 22'd1238021;
      7'd33: v = 22'd1271189; 7'd34: v = 22'd1303938; 7'd35: v = 22'd1336265;
      7'd36: v = 22'd1368170; 7'd37: v = 22'd1399652; 7'd38: v = 22'd1430711;
      7'd39: v = 22'd1461346; 7'd40: v = 22'd1491559; 7'd41: v = 22'd1521350;
      7'd42: v = 22'd1550722; 7'd43: v = 22'd1579676; 7'd44: v = 22'd1608214;
      7'd45: v = 22'd1636338; 7'd46: v = 22'd1664052; 7'd47: v = 22'd1691359;
      7'd48: v = 22'd1718262; 7'd49: v = 22'd1744764; 7'd50: v = 22'd1770869;
      7'd51: v = 22'd1796582; 7'd52: v = 22'd1821906; 7'd53: v = 22'd1846846;
      7'd54: v = 22'd1871405; 7'd55: v = 22'd1895590; 7'd56: v = 22'd1919403;
      7'd57: v = 22'd1942851; 7'd58: v = 22'd1965938; 7'd59: v = 22'd1988668;
      7'd60: v = 22'd2011047; 7'd61: v = 22'd2033080; 7'd62: v = 22'd2054772;
      7'd63: v = 22'd2076127; 7'd64: v = 22'd2097152;
      default: v = 22'd2097152;
    endcase
    return v;
  endfunction

endpackage

[rtl/vector_to_heading_atan2.sv]
// ----------------------------------------------------------------------------
// vector_to_heading_atan2
// Heading of a screen-axis vector by table interpolated arctangent.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel vec_valid/vec_ready carries vec_x (right) and vec_y (down),
//   32-bit signed. Output channel head_valid/head_ready carries heading, a
//   24-bit 16.16 angle, 256 units per turn, 0 north, 64 east.
//   One item is worked at a time; vec_ready is high only when the sequencer
//   is idle. A zero vector goes straight to the output step. Otherwise the
//   one-bit-per-cycle scaling shifter halves both magnitudes k times, k
//   (0..17), until both fit within 15 bits; the one-bit-per-cycle shared
//   divider then finds the table index (7 steps) and, unless the vector is
//   an exact diagonal, the interpolation fraction (16 steps).
//   The result sits in an output register: the next item is accepted while
//   an earlier heading waits for head_ready. If the receiver stalls longer,
//   the finished item holds in its last step until the register frees.
//   Synchronous reset returns to idle and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vector_to_heading_atan2_defines.svh"

module vector_to_heading_atan2
  import vth_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     vec_valid,
  output logic                     vec_ready,
  input  logic signed [MAG_W-1:0]  vec_x,
  input  logic signed [MAG_W-1:0]  vec_y,
  output logic                     head_valid,
  input  logic                     head_ready,
  output logic        [HEAD_W-1:0] heading
);

  state_t state, state_next;

  logic [MAG_W-1:0]  mx, my;
  logic              neg_x, neg_y, zero, swap;
  logic [SM_W-1:0]   big;
  logic [ANG_W-1:0]  base, oct;
  logic [DIFF_W-1:0] step;
  logic [SM_W-1:0]   rem1;

  div_cmd_t div_cmd;
  div_res_t div_res;

  logic             accept;
  logic [MAG_W-1:0] abs_x, abs_y;
  logic             shift_need;
  logic             swap_c;
  logic [SM_W-1:0]  small_c, big_c;
  logic [IDX_W-1:0] idx;
  logic [PROD_W-1:0] prod;
  logic [HW_W-1:0]  ang, head_c;
  logic             out_free;

  assign accept   = vec_valid && vec_ready;
  assign out_free = !head_valid || head_ready;

  // Magnitudes; the most negative input maps to 2^31 by two's negation
  assign abs_x = vec_x[MAG_W-1] ? (~vec_x + 1'b1) : vec_x;
  assign abs_y = vec_y[MAG_W-1] ? (~vec_y + 1'b1) : vec_y;

  // Scaling and octant setup
  assign shift_need = (mx[MAG_W-1:SM_W] != '0) || (my[MAG_W-1:SM_W] != '0);
  assign swap_c     = mx[SM_W-1:0] > my[SM_W-1:0];
  assign small_c    = swap_c ? my[SM_W-1:0] : mx[SM_W-1:0];
  assign big_c      = swap_c ? mx[SM_W-1:0] : my[SM_W-1:0];

  assign idx  = div_res.quo[IDX_W-1:0];
  assign prod = PROD_W'(step * rem1);

  // Mirror about 45 degrees, then map into the quadrant
  always_comb begin
    ang = swap ? (ANG_QUARTER - HW_W'(oct)) : HW_W'(oct);
    case ({neg_x, neg_y})
      2'b00:   head_c = ang;
      2'b01:   head_c = ANG_HALF - ang;
      2'b11:   head_c = ANG_HALF + ang;
      default: head_c = ANG_TURN - ang;
    endcase
    if (zero) begin
      head_c = '0;
    end
  end

  vth_div u_div (
    .clk     (clk),
    .rst     (rst),
    .cmd     (div_cmd),
    .divisor (big),
    .res     (div_res)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and divider commands
  always_comb begin
    state_next       = state;
    vec_ready        = 1'b0;
    div_cmd.start    = 1'b0;
    div_cmd.rem_init = '0;
    div_cmd.low      = '0;
    div_cmd.steps    = '0;
    case (state)
      S_IDLE: begin
        vec_ready = 1'b1;
        if (vec_valid) begin
          state_next = ((abs_x == '0) && (abs_y == '0)) ? S_FIN : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!shift_need) begin
          // num = small << 6: preload small >> 1, shift in the rest
          div_cmd.start    = 1'b1;
          div_cmd.rem_init = small_c >> 1;
          div_cmd.low      = {small_c[0], {(LOW_W-1){1'b0}}};
          div_cmd.steps    = Q1_STEPS;
          state_next       = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_res.done) begin
          state_next = (idx == IDX_LAST) ? S_FIN : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_next = S_PROD;
      end
      S_PROD: begin
        div_cmd.start    = 1'b1;
        div_cmd.rem_init = prod[PROD_W-1:LOW_W];
        div_cmd.low      = prod[LOW_W-1:0];
        div_cmd.steps    = Q2_STEPS;
        state_next       = S_DIV2;
      end
      S_DIV2: begin
        if (div_res.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mx    <= abs_x;
          my    <= abs_y;
          neg_x <= vec_x[MAG_W-1];
          neg_y <= (vec_y != '0) && !vec_y[MAG_W-1];
          zero  <= (abs_x == '0) && (abs_y == '0);
        end
      end
      S_SHIFT: begin
        if (shift_need) begin
          mx <= mx >> 1;
          my <= my >> 1;
        end else begin
          swap <= swap_c;
          big  <= big_c;
        end
      end
      S_DIV1: begin
        if (div_res.done) begin
          oct <= atan_rom(idx);
        end
      end
      S_LOOKUP: begin
        base <= atan_rom(idx);
        step <= DIFF_W'(atan_rom(idx + 1'b1) - atan_rom(idx));
        rem1 <= div_res.rem;
      end
      S_DIV2: begin
        if (div_res.done) begin
          oct <= base + ANG_W'(div_res.quo);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      head_valid <= 1'b1;
    end else if (head_ready) begin
      head_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      heading <= head_c[HEAD_W-1:0];
    end
  end

  // Checks
  `VTH_ASSERT_IMP(a_div_nonzero, (state == S_DIV1 || state == S_DIV2), big != '0,
    "divider running with zero divisor")
  `VTH_ASSERT_IMP(a_scaled, state == S_DIV1, !shift_need,
    "division started before magnitudes were scaled")
  `VTH_ASSERT_IMP(a_idx_range, (state == S_DIV1 && div_res.done), div_res.quo <= 16'd64,
    "table index above the last entry")
  `VTH_ASSERT_NXT(a_div_start, div_cmd.start, div_res.busy && !div_res.done,
    "divider did not take its command")

endmodule

[rtl/vth_div.sv]
// ----------------------------------------------------------------------------
// vth_div
// Shared restoring divider, one quotient bit per cycle. The remainder is
// preloaded below the divisor and the low dividend bits are shifted in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vth_div
  import vth_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  div_cmd_t        cmd,
  input  logic [SM_W-1:0] divisor,
  output div_res_t        res
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SM_W-1:0]  rem;
  logic [LOW_W-1:0] low;
  logic [LOW_W-1:0] quo;

  logic [SM_W:0] trial;
  logic [SM_W:0] trial_sub;
  logic          fits;

  // One trial subtract
  assign trial     = {rem, low[LOW_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = trial >= {1'b0, divisor};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= cmd.steps;
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= cmd.rem_init;
      low <= cmd.low;
      quo <= '0;
    end else if (busy && cnt != '0) begin
      rem <= fits ? trial_sub[SM_W-1:0] : trial[SM_W-1:0];
      low <= {low[LOW_W-2:0], 1'b0};
      quo <= {quo[LOW_W-2:0], fits};
    end
  end

  assign res.busy = busy;
  assign res.done = busy && (cnt == '0);
  assign res.quo  = quo;
  assign res.rem  = rem;

endmodule
